FILE: hw/rtl/pmc_pkg.sv
package pmc_pkg;

    // Datapath sizing
    localparam int DUTY_BITS     = 10;
    localparam int INTEGRAL_BITS = 40;

    localparam int POS_BITS      = 18;
    localparam int TRAVEL_BITS   = 16;
    localparam int DEADZONE_BITS = 8;
    localparam int GAIN_BITS     = 24;
    localparam int MIN_DUTY_BITS = 17;
    localparam int TARGET_BITS   = 17;
    localparam int MAG_BITS      = 17;
    localparam int STATUS_BITS   = 2;
    localparam int ERR_BITS      = POS_BITS + 1;
    localparam int P_BITS        = GAIN_BITS + ERR_BITS + 1;
    localparam int INT_LO_BITS   = INTEGRAL_BITS / 2;
    localparam int INT_HI_BITS   = INTEGRAL_BITS - INT_LO_BITS;
    localparam int IPROD_BITS    = GAIN_BITS + INTEGRAL_BITS + 1;
    localparam int TERM_BITS     = 42;
    localparam int R_BITS        = P_BITS + 1;
    localparam int SHAPED_BITS   = MAG_BITS + 1;

    localparam int Q16_ONE = 65536;

    // Stream packing
    localparam int S_FIELD_BITS = 2 * POS_BITS + 1;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 2 * DUTY_BITS + 1 + STATUS_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TRAVEL_SPAN = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEADZONE    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_P      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_I      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_DUTY    = 3'd4;

    localparam logic [TRAVEL_BITS-1:0]   TRAVEL_SPAN_RST = 16'd1000;
    localparam logic [DEADZONE_BITS-1:0] DEADZONE_RST    = 8'd2;
    localparam logic [GAIN_BITS-1:0]     GAIN_RST        = 24'd0;
    localparam logic [MIN_DUTY_BITS-1:0] MIN_DUTY_RST    = 17'd26214;

    // Target request status
    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BUSY    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_SMALL   = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_CLAMPED = 2'd3;

    typedef struct packed {
        logic [TRAVEL_BITS-1:0]   travel_span;
        logic [DEADZONE_BITS-1:0] deadzone;
        logic [GAIN_BITS-1:0]     gain_p;
        logic [GAIN_BITS-1:0]     gain_i;
        logic [MIN_DUTY_BITS-1:0] min_duty;
    } cfg_t;

    typedef struct packed {
        logic [MAG_BITS-1:0]  mag;
        logic                 dir;
        logic [DUTY_BITS-1:0] duty;
    } drive_t;

endpackage

FILE: hw/rtl/pmc_cfg_regs.sv
module pmc_cfg_regs import pmc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.travel_span <= TRAVEL_SPAN_RST;
            cfg_reg.deadzone    <= DEADZONE_RST;
            cfg_reg.gain_p      <= GAIN_RST;
            cfg_reg.gain_i      <= GAIN_RST;
            cfg_reg.min_duty    <= MIN_DUTY_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TRAVEL_SPAN: cfg_reg.travel_span <= cfg_wdata[TRAVEL_BITS-1:0];
                REG_DEADZONE:    cfg_reg.deadzone    <= cfg_wdata[DEADZONE_BITS-1:0];
                REG_GAIN_P:      cfg_reg.gain_p      <= cfg_wdata[GAIN_BITS-1:0];
                REG_GAIN_I:      cfg_reg.gain_i      <= cfg_wdata[GAIN_BITS-1:0];
                REG_MIN_DUTY:    cfg_reg.min_duty    <= cfg_wdata[MIN_DUTY_BITS-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/pmc_pi_shaper.sv
module pmc_pi_shaper import pmc_pkg::*; (
    input  cfg_t                            cfg,
    input  logic signed [P_BITS-1:0]        p_term,
    input  logic signed [INTEGRAL_BITS-1:0] integral,
    output drive_t                          drive
);

    localparam int HI_PROD_BITS = GAIN_BITS + INT_HI_BITS + 1;

    localparam logic signed [IPROD_BITS-1:0] ITERM_LIMIT = IPROD_BITS'(64'sh100_0000_0000);
    localparam logic signed [IPROD_BITS-1:0] ITERM_HALF  = IPROD_BITS'(64'sh80_0000_0000);
    localparam logic signed [R_BITS-1:0]      R_ONE       = R_BITS'(Q16_ONE);
    localparam logic signed [SHAPED_BITS-1:0] SHAPED_ONE  = SHAPED_BITS'(Q16_ONE);

    logic [GAIN_BITS+INT_LO_BITS-1:0]   prod_lo;
    logic signed [HI_PROD_BITS-1:0]     prod_hi;
    logic signed [IPROD_BITS-1:0]       iprod;
    logic signed [IPROD_BITS-1:0]       int_ext;
    logic signed [TERM_BITS-1:0]        iterm;
    logic signed [R_BITS-1:0]           r_sum;
    logic signed [R_BITS-1:0]           floor_r;
    logic [MIN_DUTY_BITS-1:0]           floor_q;
    logic signed [SHAPED_BITS-1:0]      floor_s;
    logic signed [SHAPED_BITS-1:0]      shaped;
    logic [MAG_BITS-1:0]                mag;
    logic [MAG_BITS+DUTY_BITS-1:0]      scaled;

    // Split the integral product into two half-width partial products
    assign prod_lo = {{INT_LO_BITS{1'b0}}, cfg.gain_i}
                   * {{GAIN_BITS{1'b0}}, integral[INT_LO_BITS-1:0]};
    assign prod_hi = $signed({{(INT_HI_BITS+1){1'b0}}, cfg.gain_i})
                   * $signed({{(GAIN_BITS+1){integral[INTEGRAL_BITS-1]}},
                              integral[INTEGRAL_BITS-1:INT_LO_BITS]});

    assign iprod = ($signed({{(IPROD_BITS-HI_PROD_BITS){prod_hi[HI_PROD_BITS-1]}}, prod_hi})
                    <<< INT_LO_BITS)
                 + $signed({{(IPROD_BITS-GAIN_BITS-INT_LO_BITS){1'b0}}, prod_lo});

    assign int_ext = $signed({{(IPROD_BITS-INTEGRAL_BITS){integral[INTEGRAL_BITS-1]}},
                              integral});

    always_comb begin
        priority if (cfg.gain_i == '0) begin
            iterm = '0;
        end else if (int_ext >= ITERM_HALF) begin
            iterm = TERM_BITS'(ITERM_LIMIT);
        end else if (int_ext <= -ITERM_HALF) begin
            iterm = TERM_BITS'(-ITERM_LIMIT);
        end else if (iprod > ITERM_LIMIT) begin
            iterm = TERM_BITS'(ITERM_LIMIT);
        end else if (iprod < -ITERM_LIMIT) begin
            iterm = TERM_BITS'(-ITERM_LIMIT);
        end else begin
            iterm = iprod[TERM_BITS-1:0];
        end
    end

    assign r_sum = $signed({{(R_BITS-P_BITS){p_term[P_BITS-1]}}, p_term})
                 + $signed({{(R_BITS-TERM_BITS){iterm[TERM_BITS-1]}}, iterm});

    assign floor_q = (cfg.min_duty > MIN_DUTY_BITS'(Q16_ONE)) ? MIN_DUTY_BITS'(Q16_ONE)
                                                              : cfg.min_duty;
    assign floor_r = $signed({{(R_BITS-MIN_DUTY_BITS){1'b0}}, floor_q});
    assign floor_s = $signed({1'b0, floor_q});

    // Saturate to full scale, lift small nonzero drive to the duty floor
    always_comb begin
        priority if (r_sum < -R_ONE) begin
            shaped = -SHAPED_ONE;
        end else if (r_sum > -floor_r && r_sum < 0) begin
            shaped = -floor_s;
        end else if (r_sum > 0 && r_sum < floor_r) begin
            shaped = floor_s;
        end else if (r_sum > R_ONE) begin
            shaped = SHAPED_ONE;
        end else begin
            shaped = r_sum[SHAPED_BITS-1:0];
        end
    end

    assign mag = shaped[SHAPED_BITS-1] ? MAG_BITS'(-shaped) : shaped[MAG_BITS-1:0];

    // mag * (2^DUTY_BITS - 1) >> 16
    assign scaled = {mag, {DUTY_BITS{1'b0}}} - {{DUTY_BITS{1'b0}}, mag};

    assign drive.mag  = mag;
    assign drive.dir  = !shaped[SHAPED_BITS-1];
    assign drive.duty = scaled[MAG_BITS+DUTY_BITS-2:MAG_BITS-1];

endmodule

FILE: hw/rtl/pi_position_motor_controller_unit.sv
// PI position controller for a two-channel PWM motor drive.
// Input stream: one beat per item. s_tuser selects the item kind (0 control
// tick, 1 new-target request); s_tdata carries position, stop and new_target.
// Result stream: exactly one beat per input beat, in order, carrying both
// duties, the moving flag and the target request status.
// Configuration: cfg_wr_en registers cfg_wdata into the register at cfg_index;
// write only while no item is in flight.
// Path: an accepted beat passes the input, first-cycle and output registers
// before it shows on m_tvalid; the next beat is taken as the output register
// loads. The first cycle forms the error, updates the integral and takes the
// proportional product; the second forms the integral product, shapes the
// drive and loads the output register. Each tick needs the drive magnitude
// left by the previous one, so the work cycles of two items never overlap.
// Receiver stall: the result holds in the output register; one more beat is
// accepted and waits with its first-cycle results held until the output frees.
// Reset: registers return to their defaults, target, setpoint, integral and
// drive state clear, and no result is pending.
module pi_position_motor_controller_unit import pmc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [S_TDATA_BITS-1:0]   s_tdata,   // position, stop, new_target
    input  logic [0:0]                s_tuser,   // cmd
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [M_TDATA_BITS-1:0]   m_tdata,   // duty_forward, duty_reverse, moving,
                                                 // target_status
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam logic [1:0] KIND_REQ   = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_IDLE  = 2'd2;
    localparam logic [1:0] KIND_DRIVE = 2'd3;

    localparam logic signed [INTEGRAL_BITS:0] INT_LIMIT =
        $signed({2'b00, {(INTEGRAL_BITS-1){1'b1}}});

    cfg_t   cfg;
    drive_t drive;

    // Handshake and sequencing
    logic phase_a_reg, phase_b_reg, out_valid_reg;
    logic accept, b_fire;

    // Input beat
    logic                       in_cmd_reg;
    logic                       in_stop_reg;
    logic signed [POS_BITS-1:0] in_pos_reg;
    logic signed [POS_BITS-1:0] in_new_target_reg;

    // Controller state
    logic [TARGET_BITS-1:0]          target_reg;
    logic [TARGET_BITS-1:0]          setpoint_reg;
    logic signed [INTEGRAL_BITS-1:0] integral_reg;
    logic [MAG_BITS-1:0]             last_mag_reg;
    logic                            dir_reg;
    logic                            moving_reg;

    // First-cycle results
    logic [1:0]                kind_reg;
    logic [STATUS_BITS-1:0]    status_reg;
    logic signed [P_BITS-1:0]  p_reg;

    // Output beat
    logic [DUTY_BITS-1:0]   out_fwd_reg, out_rev_reg;
    logic                   out_moving_reg;
    logic [STATUS_BITS-1:0] out_status_reg;

    // First-cycle logic
    logic signed [ERR_BITS-1:0]      tgt_ext, pos_ext, req_ext, err, delta;
    logic [ERR_BITS-1:0]             aerr, adelta;
    logic                            changed, drive_a;
    logic signed [INTEGRAL_BITS:0]   int_sum, int_sat;
    logic signed [P_BITS-1:0]        p_full;
    logic [1:0]                      kind_a;
    logic [STATUS_BITS-1:0]          req_status;
    logic [TARGET_BITS-1:0]          req_target;

    pmc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pmc_pi_shaper u_shaper (
        .cfg      (cfg),
        .p_term   (p_reg),
        .integral (integral_reg),
        .drive    (drive)
    );

    assign b_fire   = phase_b_reg && (!out_valid_reg || m_tready);
    assign s_tready = !phase_a_reg && (!phase_b_reg || b_fire);
    assign accept   = s_tvalid && s_tready;

    assign tgt_ext = $signed({{(ERR_BITS-TARGET_BITS){1'b0}}, target_reg});
    assign pos_ext = $signed({in_pos_reg[POS_BITS-1], in_pos_reg});
    assign req_ext = $signed({in_new_target_reg[POS_BITS-1], in_new_target_reg});

    assign err     = tgt_ext - pos_ext;
    assign aerr    = err[ERR_BITS-1] ? ERR_BITS'(-err) : ERR_BITS'(err);
    assign changed = (setpoint_reg != target_reg);
    assign drive_a = (aerr > {{(ERR_BITS-DEADZONE_BITS){1'b0}}, cfg.deadzone}) && !changed;

    assign int_sum = $signed({integral_reg[INTEGRAL_BITS-1], integral_reg})
                   + $signed({{(INTEGRAL_BITS+1-ERR_BITS){err[ERR_BITS-1]}}, err});

    always_comb begin
        priority if (int_sum > INT_LIMIT) begin
            int_sat = INT_LIMIT;
        end else if (int_sum < -INT_LIMIT) begin
            int_sat = -INT_LIMIT;
        end else begin
            int_sat = int_sum;
        end
    end

    assign p_full = $signed({{(P_BITS-GAIN_BITS){1'b0}}, cfg.gain_p})
                  * $signed({{(P_BITS-ERR_BITS){err[ERR_BITS-1]}}, err});

    // New-target request: the deadzone test uses the unclamped value
    assign delta  = req_ext - tgt_ext;
    assign adelta = delta[ERR_BITS-1] ? ERR_BITS'(-delta) : ERR_BITS'(delta);

    always_comb begin
        req_target = target_reg;
        priority if (moving_reg) begin
            req_status = ST_BUSY;
        end else if (adelta < {{(ERR_BITS-DEADZONE_BITS){1'b0}}, cfg.deadzone}) begin
            req_status = ST_SMALL;
        end else if (req_ext > $signed({{(ERR_BITS-TRAVEL_BITS){1'b0}}, cfg.travel_span})) begin
            req_status = ST_CLAMPED;
            req_target = TARGET_BITS'(cfg.travel_span);
        end else if (req_ext[ERR_BITS-1]) begin
            req_status = ST_CLAMPED;
            req_target = '0;
        end else begin
            req_status = ST_OK;
            req_target = req_ext[TARGET_BITS-1:0];
        end
    end

    always_comb begin
        priority if (in_cmd_reg) begin
            kind_a = KIND_REQ;
        end else if (in_stop_reg) begin
            kind_a = KIND_STOP;
        end else if (drive_a) begin
            kind_a = KIND_DRIVE;
        end else begin
            kind_a = KIND_IDLE;
        end
    end

    // Control and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_a_reg   <= 1'b0;
            phase_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
            setpoint_reg  <= '0;
            integral_reg  <= '0;
            last_mag_reg  <= '0;
            dir_reg       <= 1'b0;
            moving_reg    <= 1'b0;
        end else begin
            phase_a_reg   <= accept;
            phase_b_reg   <= phase_a_reg || (phase_b_reg && !b_fire);
            out_valid_reg <= b_fire || (out_valid_reg && !m_tready);

            if (phase_a_reg) begin
                unique case (kind_a)
                    KIND_REQ: begin
                        target_reg <= req_target;
                    end
                    KIND_STOP: begin
                        // hold all loop state
                    end
                    KIND_DRIVE: begin
                        setpoint_reg <= target_reg;
                        // anti-windup: freeze the integral while saturated
                        if (!last_mag_reg[MAG_BITS-1]) begin
                            integral_reg <= int_sat[INTEGRAL_BITS-1:0];
                        end
                    end
                    KIND_IDLE: begin
                        setpoint_reg <= target_reg;
                        integral_reg <= '0;
                    end
                endcase
            end

            if (b_fire) begin
                unique case (kind_reg)
                    KIND_REQ: begin
                        // state already settled in the first cycle
                    end
                    KIND_STOP: begin
                        moving_reg <= 1'b0;
                    end
                    KIND_DRIVE: begin
                        moving_reg   <= 1'b1;
                        last_mag_reg <= drive.mag;
                        dir_reg      <= drive.dir;
                    end
                    KIND_IDLE: begin
                        moving_reg   <= 1'b0;
                        last_mag_reg <= '0;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_cmd_reg        <= s_tuser[0];
            in_pos_reg        <= s_tdata[POS_BITS-1:0];
            in_stop_reg       <= s_tdata[POS_BITS];
            in_new_target_reg <= s_tdata[2*POS_BITS:POS_BITS+1];
        end
        if (phase_a_reg) begin
            kind_reg   <= kind_a;
            status_reg <= req_status;
            p_reg      <= p_full;
        end
        if (b_fire) begin
            unique case (kind_reg)
                KIND_REQ: begin
                    out_fwd_reg    <= '0;
                    out_rev_reg    <= '0;
                    out_moving_reg <= moving_reg;
                    out_status_reg <= status_reg;
                end
                KIND_DRIVE: begin
                    out_fwd_reg    <= drive.dir ? drive.duty : '0;
                    out_rev_reg    <= drive.dir ? '0 : drive.duty;
                    out_moving_reg <= 1'b1;
                    out_status_reg <= ST_OK;
                end
                KIND_STOP, KIND_IDLE: begin
                    out_fwd_reg    <= '0;
                    out_rev_reg    <= '0;
                    out_moving_reg <= 1'b0;
                    out_status_reg <= ST_OK;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_BITS-M_FIELD_BITS){1'b0}},
                       out_status_reg, out_moving_reg, out_rev_reg, out_fwd_reg};

    // The first and second work cycles never coincide
    a_phase_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(phase_a_reg && phase_b_reg))
        else $error("first and second work cycles overlap");

    a_phase_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_a_reg |=> phase_b_reg)
        else $error("first work cycle not followed by second");

    a_b_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_b_reg && !b_fire) |=> (phase_b_reg && $stable(kind_reg)))
        else $error("stalled item lost its place");

    a_one_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_fwd_reg != '0) |-> (out_rev_reg == '0))
        else $error("both drive channels active");

    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        last_mag_reg <= MAG_BITS'(Q16_ONE))
        else $error("drive magnitude beyond full scale");

endmodule
